// ===== rtl/core/rds_pkg.sv =====
// Shared types, register indexes and reset values of the recovery deploy sequencer.
package rds_pkg;

	localparam int ALT_W = 15;
	localparam int REL_W = 14;
	localparam int IDX_W = 8;

	// Flight phases, coded as the phase output reports them
	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_ASCENDING  = 3'd1,
		PH_DESCENDING = 3'd2,
		PH_FINAL      = 3'd3,
		PH_TOUCHDOWN  = 3'd4
	} phase_t;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] CFG_LAUNCH    = IDX_W'(0);
	localparam logic [IDX_W-1:0] CFG_ARMING    = IDX_W'(1);
	localparam logic [IDX_W-1:0] CFG_RELEASE   = IDX_W'(2);
	localparam logic [IDX_W-1:0] CFG_TOUCHDOWN = IDX_W'(3);

	// Reset values, altitude in 2 m units
	localparam logic [ALT_W-1:0] LAUNCH_RST    = ALT_W'(30 / 2);
	localparam logic [ALT_W-1:0] ARMING_RST    = ALT_W'(25 / 2);
	localparam logic [REL_W-1:0] RELEASE_RST   = '0;
	localparam logic [ALT_W-1:0] TOUCHDOWN_RST = ALT_W'(50 / 2);

	typedef struct packed {
		logic [ALT_W-1:0] launch_thr;
		logic [ALT_W-1:0] arming_thr;
		logic [REL_W-1:0] release_alt;
		logic [ALT_W-1:0] touchdown_thr;
	} cfg_t;

	typedef struct packed {
		logic             apogee_valid;
		logic [ALT_W-1:0] apogee;
		logic             deploy;
		phase_t           phase;
	} result_t;

endpackage

// ===== rtl/core/rds_cfg_regs.sv =====
// Configuration register file of the recovery deploy sequencer.
module rds_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [rds_pkg::IDX_W-1:0] wr_index,
	input  logic [rds_pkg::ALT_W-1:0] wr_data,
	output rds_pkg::cfg_t             cfg
);
	import rds_pkg::*;

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.launch_thr    <= LAUNCH_RST;
			cfg_q.arming_thr    <= ARMING_RST;
			cfg_q.release_alt   <= RELEASE_RST;
			cfg_q.touchdown_thr <= TOUCHDOWN_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_LAUNCH:    cfg_q.launch_thr    <= wr_data;
				CFG_ARMING:    cfg_q.arming_thr    <= wr_data;
				CFG_RELEASE:   cfg_q.release_alt   <= wr_data[REL_W-1:0];
				CFG_TOUCHDOWN: cfg_q.touchdown_thr <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/rds_phase_fsm.sv =====
// Flight phase state machine with apogee capture and deploy latch.
module rds_phase_fsm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [rds_pkg::ALT_W-1:0] alt,
	input  rds_pkg::cfg_t             cfg,
	output rds_pkg::result_t          res
);
	import rds_pkg::*;

	phase_t           phase_q, phase_d;
	logic [ALT_W-1:0] prev_q;
	logic [ALT_W-1:0] apogee_q, apogee_d;
	logic             seen_q, seen_d;
	logic             deploy_q, deploy_d;

	// State registers, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			prev_q   <= '0;
			apogee_q <= '0;
			seen_q   <= 1'b0;
			deploy_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			prev_q   <= alt;
			apogee_q <= apogee_d;
			seen_q   <= seen_d;
			deploy_q <= deploy_d;
		end
	end

	// Next phase; all compares are signed on 2 m units
	always_comb begin
		phase_d  = phase_q;
		apogee_d = apogee_q;
		seen_d   = seen_q;
		deploy_d = deploy_q;
		unique case (phase_q)
			PH_IDLE: begin
				if ($signed(alt) >= $signed(cfg.launch_thr))
					phase_d = PH_ASCENDING;
			end
			PH_ASCENDING: begin
				// arming loss wins over apogee detection
				if ($signed(alt) <= $signed(cfg.arming_thr)) begin
					phase_d = PH_DESCENDING;
				end else if ($signed(alt) < $signed(prev_q)) begin
					apogee_d = prev_q;
					seen_d   = 1'b1;
					phase_d  = PH_DESCENDING;
				end
			end
			PH_DESCENDING: begin
				if ($signed(alt) < $signed({1'b0, cfg.release_alt})) begin
					deploy_d = 1'b1;
					phase_d  = PH_FINAL;
				end
			end
			PH_FINAL: begin
				if ($signed(alt) < $signed(cfg.touchdown_thr))
					phase_d = PH_TOUCHDOWN;
			end
			default: phase_d = PH_TOUCHDOWN;
		endcase

		res.phase        = phase_d;
		res.deploy       = deploy_d;
		res.apogee       = apogee_d;
		res.apogee_valid = seen_d;
	end

endmodule

// ===== rtl/core/recovery_deploy_sequencer.sv =====
// Top level of the recovery deploy sequencer: input stage, phase logic, result stage.
//
//  channel  | signals                              | item
//  ---------+--------------------------------------+------------------------------
//  s_       | s_tvalid s_tready s_tdata[15:0]      | altitude sample
//  m_       | m_tvalid m_tready m_tdata[23:0]      | phase, deploy, apogee, valid
//  cfg_     | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// One item per cycle sustained while the output is not stalled; a result is offered
// once its sample has passed the input register and then the result register. The
// phase update is one stage of compares between those registers. Reset clears the
// phase, apogee, deploy latch and registers to their defaults. A stalled output
// holds the result and one sample in the input register; the sample side stalls then.
module recovery_deploy_sequencer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,   // [14:0] altitude, [15] zero fill
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata,   // [2:0] phase, [3] deploy,
	                                             // [18:4] apogee, [19] apogee_valid
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rds_pkg::IDX_W-1:0] cfg_index,
	input  logic [rds_pkg::ALT_W-1:0] cfg_data
);
	import rds_pkg::*;

	cfg_t             cfg;
	result_t          res;
	logic             vld_s1, vld_s2;
	logic [ALT_W-1:0] alt_s1;
	result_t          res_s2;
	logic             advance;

	assign cfg_ready = 1'b1;

	rds_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input stage moves on when the result register is free or being drained
	assign advance  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			alt_s1 <= s_tdata[ALT_W-1:0];
	end

	rds_phase_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.alt    (alt_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (!vld_s2 || m_tready)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {4'b0, res_s2.apogee_valid, res_s2.apogee, res_s2.deploy,
		res_s2.phase};

endmodule
